// File: rtl/b2r_pkg.sv
// b2r_pkg: types, control word layout, microcode codes and letter tables
// for the binary to Roman numeral converter. No dependencies.
package b2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 7;
    localparam int ADDR_W   = 4;
    localparam int DIG_W    = 4;
    localparam int POS_W    = 2;
    localparam int SCALE_W  = 10;
    localparam int WIDE_W   = 14;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    localparam logic [LETTER_W-1:0] ASCII_M = 7'h4D;
    localparam logic [LETTER_W-1:0] ASCII_D = 7'h44;
    localparam logic [LETTER_W-1:0] ASCII_C = 7'h43;
    localparam logic [LETTER_W-1:0] ASCII_L = 7'h4C;
    localparam logic [LETTER_W-1:0] ASCII_X = 7'h58;
    localparam logic [LETTER_W-1:0] ASCII_V = 7'h56;
    localparam logic [LETTER_W-1:0] ASCII_I = 7'h49;
    localparam logic [LETTER_W-1:0] ASCII_NUL = 7'h00;

    localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
    localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [POS_W-1:0] POS_TENS      = 2'd2;
    localparam logic [POS_W-1:0] POS_ONES      = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [2:0]        t_emit;
    typedef logic [2:0]        t_dop;
    typedef logic [1:0]        t_fin;
    typedef logic [2:0]        t_cond;

    // microcode addresses
    localparam t_addr A_WAIT  = 4'd0;
    localparam t_addr A_EXT   = 4'd1;
    localparam t_addr A_FIVE  = 4'd2;
    localparam t_addr A_ONES  = 4'd3;
    localparam t_addr A_NINE1 = 4'd4;
    localparam t_addr A_NINE2 = 4'd5;
    localparam t_addr A_FOUR1 = 4'd6;
    localparam t_addr A_FOUR2 = 4'd7;
    localparam t_addr A_ERR   = 4'd8;
    localparam t_addr A_RET   = 4'd15;  // resolves to A_WAIT or A_EXT

    localparam t_emit EMIT_NONE = 3'd0;
    localparam t_emit EMIT_ONE  = 3'd1;
    localparam t_emit EMIT_FIVE = 3'd2;
    localparam t_emit EMIT_TEN  = 3'd3;
    localparam t_emit EMIT_ERR  = 3'd4;

    localparam t_dop DOP_NONE = 3'd0;
    localparam t_dop DOP_LOAD = 3'd1;
    localparam t_dop DOP_EXT  = 3'd2;
    localparam t_dop DOP_SUB5 = 3'd3;
    localparam t_dop DOP_DEC  = 3'd4;

    localparam t_fin FIN_NO   = 2'd0;
    localparam t_fin FIN_YES  = 2'd1;
    localparam t_fin FIN_DIG1 = 2'd2;
    localparam t_fin FIN_DIG5 = 2'd3;

    localparam t_cond COND_ALWAYS   = 3'd0;
    localparam t_cond COND_IN_ERR   = 3'd1;
    localparam t_cond COND_DIG_EQ5  = 3'd2;
    localparam t_cond COND_DIG_GT1  = 3'd3;
    localparam t_cond COND_DISPATCH = 3'd4;

    typedef struct packed {
        logic  wait_in;
        t_emit emit;
        t_dop  dop;
        t_fin  fin;
        t_cond cond;
        t_addr addr_t;
        t_addr addr_f;
    } t_ctrl;

    typedef struct packed {
        logic             in_err;
        logic             dig_eq5;
        logic             dig_gt1;
        logic [DIG_W-1:0] ext_dig;
        logic             rem_zero;
        logic             out_free;
    } t_status;

    function automatic logic [SCALE_W-1:0] f_scale(input logic [POS_W-1:0] pos);
        logic [SCALE_W-1:0] s;
        case (pos)
            POS_THOUSANDS: s = 10'd1000;
            POS_HUNDREDS:  s = 10'd100;
            POS_TENS:      s = 10'd10;
            default:       s = 10'd1;
        endcase
        return s;
    endfunction

    function automatic logic [LETTER_W-1:0] f_letter(input logic [POS_W-1:0] pos,
                                                     input t_emit emit);
        logic [LETTER_W-1:0] one;
        logic [LETTER_W-1:0] five;
        logic [LETTER_W-1:0] ten;
        logic [LETTER_W-1:0] l;
        case (pos)
            POS_THOUSANDS: begin
                one = ASCII_M; five = ASCII_M; ten = ASCII_M;
            end
            POS_HUNDREDS: begin
                one = ASCII_C; five = ASCII_D; ten = ASCII_M;
            end
            POS_TENS: begin
                one = ASCII_X; five = ASCII_L; ten = ASCII_C;
            end
            default: begin
                one = ASCII_I; five = ASCII_V; ten = ASCII_X;
            end
        endcase
        case (emit)
            EMIT_ONE:  l = one;
            EMIT_FIVE: l = five;
            EMIT_TEN:  l = ten;
            default:   l = ASCII_NUL;
        endcase
        return l;
    endfunction

endpackage

// File: rtl/b2r_in_if.sv
// b2r_in_if: input channel carrying the binary value word.
// Uses b2r_pkg for widths.
interface b2r_in_if import b2r_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/b2r_out_if.sv
// b2r_out_if: output channel carrying one Roman letter word.
// Uses b2r_pkg for widths.
interface b2r_out_if import b2r_pkg::*;;
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                range_error;

    modport source (output valid, output letter, output last, output range_error,
                    input ready);
    modport sink   (input valid, input letter, input last, input range_error,
                    output ready);
endinterface

// File: rtl/b2r_ucode_rom.sv
// b2r_ucode_rom: read-only microprogram, one control word per step.
// Depends on b2r_pkg.
module b2r_ucode_rom import b2r_pkg::*; (
    input  t_addr i_addr,
    output t_ctrl o_ctrl
);

    always_comb begin
        case (i_addr)
            A_WAIT:  o_ctrl = '{1'b1, EMIT_NONE, DOP_LOAD, FIN_NO,   COND_IN_ERR,
                                A_ERR, A_EXT};
            A_EXT:   o_ctrl = '{1'b0, EMIT_NONE, DOP_EXT,  FIN_NO,   COND_DISPATCH,
                                A_RET, A_RET};
            A_FIVE:  o_ctrl = '{1'b0, EMIT_FIVE, DOP_SUB5, FIN_DIG5, COND_DIG_EQ5,
                                A_RET, A_ONES};
            A_ONES:  o_ctrl = '{1'b0, EMIT_ONE,  DOP_DEC,  FIN_DIG1, COND_DIG_GT1,
                                A_ONES, A_RET};
            A_NINE1: o_ctrl = '{1'b0, EMIT_ONE,  DOP_NONE, FIN_NO,   COND_ALWAYS,
                                A_NINE2, A_NINE2};
            A_NINE2: o_ctrl = '{1'b0, EMIT_TEN,  DOP_NONE, FIN_YES,  COND_ALWAYS,
                                A_RET, A_RET};
            A_FOUR1: o_ctrl = '{1'b0, EMIT_ONE,  DOP_NONE, FIN_NO,   COND_ALWAYS,
                                A_FOUR2, A_FOUR2};
            A_FOUR2: o_ctrl = '{1'b0, EMIT_FIVE, DOP_NONE, FIN_YES,  COND_ALWAYS,
                                A_RET, A_RET};
            A_ERR:   o_ctrl = '{1'b0, EMIT_ERR,  DOP_NONE, FIN_YES,  COND_ALWAYS,
                                A_WAIT, A_WAIT};
            default: o_ctrl = '{1'b0, EMIT_NONE, DOP_NONE, FIN_NO,   COND_ALWAYS,
                                A_WAIT, A_WAIT};
        endcase
    end

endmodule

// File: rtl/b2r_sequencer.sv
// b2r_sequencer: step counter, microcode fetch and jump resolution.
// Depends on b2r_pkg and b2r_ucode_rom.
module b2r_sequencer import b2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_fire
);

    t_addr r_step;
    t_addr n_step;
    t_addr target;
    t_addr disp;
    logic  cond_hit;

    b2r_ucode_rom u_rom (
        .i_addr (r_step),
        .o_ctrl (o_ctrl)
    );

    always_comb begin
        if (o_ctrl.wait_in) begin
            o_fire = i_in_valid;
        end else if (o_ctrl.emit != EMIT_NONE) begin
            o_fire = i_status.out_free;
        end else begin
            o_fire = 1'b1;
        end
    end

    always_comb begin
        if (i_status.ext_dig == 4'd0) begin
            disp = A_RET;
        end else if (i_status.ext_dig == 4'd9) begin
            disp = A_NINE1;
        end else if (i_status.ext_dig == 4'd4) begin
            disp = A_FOUR1;
        end else if (i_status.ext_dig >= 4'd5) begin
            disp = A_FIVE;
        end else begin
            disp = A_ONES;
        end
    end

    always_comb begin
        case (o_ctrl.cond)
            COND_IN_ERR:  cond_hit = i_status.in_err;
            COND_DIG_EQ5: cond_hit = i_status.dig_eq5;
            COND_DIG_GT1: cond_hit = i_status.dig_gt1;
            default:      cond_hit = 1'b1;
        endcase
        if (o_ctrl.cond == COND_DISPATCH) begin
            target = disp;
        end else begin
            target = cond_hit ? o_ctrl.addr_t : o_ctrl.addr_f;
        end
        if (target == A_RET) begin
            n_step = i_status.rem_zero ? A_WAIT : A_EXT;
        end else begin
            n_step = target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= A_WAIT;
        end else if (o_fire) begin
            r_step <= n_step;
        end
    end

endmodule

// File: rtl/b2r_datapath.sv
// b2r_datapath: remainder, digit and position registers, digit extraction
// and the output word register. Depends on b2r_pkg.
module b2r_datapath import b2r_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    input  logic                i_fire,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_out_ready,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [LETTER_W-1:0] o_letter,
    output logic                o_last,
    output logic                o_range_error
);

    logic [VALUE_W-1:0]  r_rem;
    logic [VALUE_W-1:0]  n_rem;
    logic [DIG_W-1:0]    r_dig;
    logic [DIG_W-1:0]    n_dig;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [LETTER_W-1:0] r_letter;
    logic                r_last;
    logic                r_err;

    logic [POS_W-1:0]    pos_x;
    logic [SCALE_W-1:0]  scale;
    logic [DIG_W-1:0]    dig_x;
    logic [WIDE_W-1:0]   weight;
    logic [VALUE_W-1:0]  rem_x;
    logic                fin_hit;
    logic                emit_fire;
    logic                out_free;

    assign pos_x = r_pos + 2'd1;
    assign scale = f_scale(pos_x);

    // largest k with k * scale <= remainder
    always_comb begin
        dig_x = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r_rem} >= WIDE_W'(k) * {4'b0000, scale}) begin
                dig_x = DIG_W'(k);
            end
        end
    end

    assign weight = {10'd0, dig_x} * {4'b0000, scale};
    assign rem_x  = r_rem - weight[VALUE_W-1:0];

    always_comb begin
        case (i_ctrl.fin)
            FIN_YES:  fin_hit = 1'b1;
            FIN_DIG1: fin_hit = (r_dig == 4'd1);
            FIN_DIG5: fin_hit = (r_dig == 4'd5);
            default:  fin_hit = 1'b0;
        endcase
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_fire = i_fire && (i_ctrl.emit != EMIT_NONE);

    always_comb begin
        n_rem = r_rem;
        n_dig = r_dig;
        n_pos = r_pos;
        if (i_fire) begin
            case (i_ctrl.dop)
                DOP_LOAD: begin
                    n_rem = i_value;
                    n_pos = POS_ONES;       // wraps to thousands on first extract
                end
                DOP_EXT: begin
                    n_rem = rem_x;
                    n_dig = dig_x;
                    n_pos = pos_x;
                end
                DOP_SUB5: n_dig = r_dig - 4'd5;
                DOP_DEC:  n_dig = r_dig - 4'd1;
                default:  n_dig = r_dig;
            endcase
        end
    end

    always_comb begin
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dig <= n_dig;
        r_pos <= n_pos;
        if (emit_fire) begin
            if (i_ctrl.emit == EMIT_ERR) begin
                r_letter <= ASCII_NUL;
                r_last   <= 1'b1;
                r_err    <= 1'b1;
            end else begin
                r_letter <= f_letter(r_pos, i_ctrl.emit);
                r_last   <= fin_hit && (r_rem == '0);
                r_err    <= 1'b0;
            end
        end
    end

    assign o_status.in_err   = (i_value == '0) || (i_value > VALUE_MAX);
    assign o_status.dig_eq5  = (r_dig == 4'd5);
    assign o_status.dig_gt1  = (r_dig > 4'd1);
    assign o_status.ext_dig  = dig_x;
    assign o_status.rem_zero = (n_rem == '0);
    assign o_status.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_letter      = r_letter;
    assign o_last        = r_last;
    assign o_range_error = r_err;

endmodule

// File: rtl/binary_to_roman_numeral.sv
// binary_to_roman_numeral: converts a 12-bit value (1..3999) to Roman letters.
// Per value: wait step, one extract step per digit up to the last nonzero one
// (at most 4), one step per letter (at most 15); an error: wait, error step.
// The microcode sequencer runs one control step per cycle; a held-off output
// word stalls the letter steps. The first letter follows the extract steps,
// an error word the wait step. Sync reset: wait step, output word emptied.
module binary_to_roman_numeral import b2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b2r_in_if.sink    i_in,
    b2r_out_if.source o_out
);

    t_ctrl   ctrl;
    t_status status;
    logic    fire;

    assign i_in.ready = ctrl.wait_in;

    b2r_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_ctrl     (ctrl),
        .o_fire     (fire)
    );

    b2r_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_fire        (fire),
        .i_value       (i_in.value),
        .i_out_ready   (o_out.ready),
        .o_status      (status),
        .o_out_valid   (o_out.valid),
        .o_letter      (o_out.letter),
        .o_last        (o_out.last),
        .o_range_error (o_out.range_error)
    );

endmodule

// File: bench/binary_to_roman_numeral_tb.sv
// Testbench for binary_to_roman_numeral: sends 12-bit values, predicts every
// Roman letter word and checks the output stream in order.
// Depends on b2r_pkg, b2r_in_if, b2r_out_if and the converter RTL.
module binary_to_roman_numeral_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b2r_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_VALUES = 245;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                range_error;
    } t_roman_letter;

    class roman_scoreboard;
        t_roman_letter       letters_due[$];
        logic [LETTER_W-1:0] spelled[$];
        int unsigned         failures;

        function new();
            failures = 0;
        endfunction

        function void spell_digit(int unsigned d, logic [LETTER_W-1:0] one,
                                  logic [LETTER_W-1:0] five, logic [LETTER_W-1:0] ten);
            int unsigned rest;
            rest = d;
            if (d == 9) begin
                spelled.push_back(one);
                spelled.push_back(ten);
            end else if (d == 4) begin
                spelled.push_back(one);
                spelled.push_back(five);
            end else begin
                if (rest >= 5) begin
                    spelled.push_back(five);
                    rest = rest - 5;
                end
                for (int unsigned k = 0; k < rest; k++) spelled.push_back(one);
            end
        endfunction

        function void note_value(logic [VALUE_W-1:0] v);
            t_roman_letter w;
            int unsigned   n;
            n = v;
            if (n == 0 || v > VALUE_MAX) begin
                w.letter      = ASCII_NUL;
                w.last        = 1'b1;
                w.range_error = 1'b1;
                letters_due.push_back(w);
            end else begin
                spelled.delete();
                spell_digit(n / 1000, ASCII_M, ASCII_M, ASCII_M);
                spell_digit((n % 1000) / 100, ASCII_C, ASCII_D, ASCII_M);
                spell_digit((n % 100) / 10, ASCII_X, ASCII_L, ASCII_C);
                spell_digit(n % 10, ASCII_I, ASCII_V, ASCII_X);
                foreach (spelled[i]) begin
                    w.letter      = spelled[i];
                    w.last        = (i == spelled.size() - 1);
                    w.range_error = 1'b0;
                    letters_due.push_back(w);
                end
            end
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void check_letter(logic [LETTER_W-1:0] letter, logic last, logic err);
            t_roman_letter want;
            if (letters_due.size() == 0) begin
                flag($sformatf("unexpected word: letter=%h last=%b range_error=%b",
                               letter, last, err));
                return;
            end
            want = letters_due.pop_front();
            if (letter !== want.letter || last !== want.last || err !== want.range_error)
                flag($sformatf({"word mismatch: exp letter=%h last=%b range_error=%b,",
                                " got letter=%h last=%b range_error=%b"},
                               want.letter, want.last, want.range_error,
                               letter, last, err));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int unsigned cycle_count = 0;

    roman_scoreboard sb = new();

    b2r_in_if  value_ch ();
    b2r_out_if letter_ch ();

    binary_to_roman_numeral dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (value_ch),
        .o_out   (letter_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_to_roman_numeral_tb failed");
            $finish;
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while (!calm && $urandom_range(99) < 7) begin
            value_ch.valid <= 1'b0;
            value_ch.value <= VALUE_W'($urandom);
            @(posedge i_clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge i_clk);
        while (value_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_value(v);
    endtask

    task automatic drain_letters();
        value_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.letters_due.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(99);
        if (r < 45) begin
            // digit-wise build hits every 4, 9 and 8 pattern often
            n = $urandom_range(3, 0) * 1000 + $urandom_range(9, 0) * 100
                + $urandom_range(9, 0) * 10 + $urandom_range(9, 0);
        end else if (r < 80) begin
            n = $urandom_range(3999, 1);
        end else if (r < 88) begin
            n = $urandom_range(4095, 4000);
        end else if (r < 92) begin
            n = 0;
        end else begin
            n = $urandom_range(4095, 0);
        end
        return VALUE_W'(n);
    endfunction

    // letter sink: random stalls plus one long hold-off
    initial begin
        int unsigned seen;
        bit          held;
        seen = 0;
        held = 1'b0;
        forever begin
            if (!held && seen >= 400) begin
                held = 1'b1;
                letter_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            letter_ch.ready <= (calm || $urandom_range(99) >= 7);
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && letter_ch.valid === 1'b1 && letter_ch.ready === 1'b1) begin
                sb.check_letter(letter_ch.letter, letter_ch.last, letter_ch.range_error);
                seen++;
            end
        end
    end

    initial begin
        logic [VALUE_W-1:0] corner_vals [25];
        corner_vals = '{12'd1, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd0, 12'd4,
                        12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd444, 12'd999,
                        12'd1994, 12'd2048, 12'd1000, 12'd500, 12'd50, 12'd5, 12'd3,
                        12'd8, 12'd2730, 12'd1365, 12'd3000};
        i_rst_n        = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        calm           = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_vals[i]) send_value(corner_vals[i]);
        drain_letters();

        for (int unsigned i = 0; i < RANDOM_VALUES; i++) begin
            calm <= (i >= 100 && i < 160);
            send_value(pick_value());
        end
        drain_letters();
        repeat (40) @(posedge i_clk);

        if (sb.failures == 0 && sb.letters_due.size() == 0) begin
            $display("binary_to_roman_numeral_tb passed");
        end else begin
            $display("binary_to_roman_numeral_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/b2r_pkg.sv
rtl/b2r_in_if.sv
rtl/b2r_out_if.sv
rtl/b2r_ucode_rom.sv
rtl/b2r_sequencer.sv
rtl/b2r_datapath.sv
rtl/binary_to_roman_numeral.sv
bench/binary_to_roman_numeral_tb.sv
